@@ sv/rgbfe_pkg.sv @@
package rgbfe_pkg;

	localparam int COLOR_BITS = 16;
	localparam int FIELD_W    = 16;
	localparam int FRAC_W     = 16;
	localparam int CNT_W      = 13;
	localparam int DIV_W      = COLOR_BITS + FRAC_W;
	localparam int ACC_W      = COLOR_BITS + FRAC_W + 3;
	localparam int HI_W       = ACC_W - 1 - FRAC_W;
	localparam int ITER_W     = $clog2(DIV_W + 1);

	localparam logic [COLOR_BITS-1:0] COLOR_MAX = '1;

	localparam logic [FIELD_W-1:0] BLINK_MIN = 16'd10;
	localparam logic [FIELD_W-1:0] FADE_MIN  = 16'd100;

	localparam logic [2:0] KIND_TICK      = 3'd0;
	localparam logic [2:0] KIND_ON        = 3'd1;
	localparam logic [2:0] KIND_OFF       = 3'd2;
	localparam logic [2:0] KIND_BLINK_ON  = 3'd3;
	localparam logic [2:0] KIND_BLINK_OFF = 3'd4;
	localparam logic [2:0] KIND_FADE      = 3'd5;

	localparam logic [1:0] RES_COLOR  = 2'd0;
	localparam logic [1:0] RES_ACCEPT = 2'd1;
	localparam logic [1:0] RES_REJECT = 2'd2;

	typedef logic [COLOR_BITS-1:0] color_t;

	typedef struct packed {
		logic start;
		logic advance;
	} lane_ctrl_t;

	function automatic color_t sat_color(input logic [FIELD_W-1:0] v);
		if (v > FIELD_W'(COLOR_MAX)) begin
			sat_color = COLOR_MAX;
		end else begin
			sat_color = v[COLOR_BITS-1:0];
		end
	endfunction

endpackage

@@ sv/rgbfe_lane.sv @@
module rgbfe_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rgbfe_pkg::lane_ctrl_t         ctrl,
	input  rgbfe_pkg::color_t             fade_from,
	input  rgbfe_pkg::color_t             fade_to,
	input  logic [rgbfe_pkg::CNT_W-1:0]   divisor,
	output logic                          busy,
	output rgbfe_pkg::color_t             level
);

	logic [rgbfe_pkg::ITER_W-1:0]       iter_q;
	logic                               neg_q;
	logic [rgbfe_pkg::CNT_W-1:0]        div_q;
	logic [rgbfe_pkg::CNT_W-1:0]        rem_q;
	logic [rgbfe_pkg::DIV_W-1:0]        quo_q;
	logic signed [rgbfe_pkg::ACC_W-1:0] acc_q;

	logic [rgbfe_pkg::CNT_W:0]          trial;
	logic [rgbfe_pkg::CNT_W:0]          trial_sub;
	logic                               ge;
	rgbfe_pkg::color_t                  mag;
	logic signed [rgbfe_pkg::ACC_W-1:0] quo_ext;
	logic signed [rgbfe_pkg::ACC_W-1:0] step;
	logic [rgbfe_pkg::HI_W-1:0]         hi;

	always_comb begin
		busy      = (iter_q != '0);
		trial     = {rem_q, quo_q[rgbfe_pkg::DIV_W-1]};
		trial_sub = trial - {1'b0, div_q};
		ge        = (trial >= {1'b0, div_q});
		if (fade_to >= fade_from) begin
			mag = fade_to - fade_from;
		end else begin
			mag = fade_from - fade_to;
		end
		quo_ext = rgbfe_pkg::ACC_W'(quo_q);
		step    = neg_q ? -quo_ext : quo_ext;
		hi      = acc_q[rgbfe_pkg::ACC_W-2:rgbfe_pkg::FRAC_W];
		if (acc_q[rgbfe_pkg::ACC_W-1]) begin
			level = '0;
		end else if (hi > rgbfe_pkg::HI_W'(rgbfe_pkg::COLOR_MAX)) begin
			level = rgbfe_pkg::COLOR_MAX;
		end else begin
			level = hi[rgbfe_pkg::COLOR_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (ctrl.start) begin
			iter_q <= rgbfe_pkg::ITER_W'(rgbfe_pkg::DIV_W);
		end else if (busy) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	// radix-2 restoring divide of the scaled color difference, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			neg_q <= (fade_to < fade_from);
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= {mag, {rgbfe_pkg::FRAC_W{1'b0}}};
			acc_q <= rgbfe_pkg::ACC_W'({fade_from, {rgbfe_pkg::FRAC_W{1'b0}}});
		end else if (busy) begin
			rem_q <= ge ? trial_sub[rgbfe_pkg::CNT_W-1:0] : trial[rgbfe_pkg::CNT_W-1:0];
			quo_q <= {quo_q[rgbfe_pkg::DIV_W-2:0], ge};
		end else if (ctrl.advance) begin
			acc_q <= acc_q + step;
		end
	end

endmodule

@@ sv/rgb_led_blink_fade_engine.sv @@
// RGB LED blink and fade engine.
// Command channel (cmd_valid / cmd_ready): one item per command or tick; kind selects
// tick, on, off, blink then on, blink then off, or fade. Result channel
// (res_valid / res_ready): one item per command and up to two per tick; last marks
// the final one. Status results (accepted, rejected) carry zero colors.
// A result is registered: it is valid in the cycle after its item is accepted. A valid
// fade command first runs a radix-2 divide in each of the three color lanes, one
// quotient bit per cycle, so its accepted status appears once every divide is done.
// Flow: one item at a time. cmd_ready is high only when no result is pending and no
// divide runs, so each item waits until every result of the one before is taken;
// a tick that produces no result leaves cmd_ready high.
// Fade steps use a per-lane accumulator, so a fade tick costs no more than a blink tick.
// Reset: mode goes idle, counters and engine color registers clear, no result is pending.
// Receiver stall: the result register holds its item while res_ready is low and no
// new command item is taken until every result of the current item has been taken.
module rgb_led_blink_fade_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  kind,
	input  logic [15:0] color_red,
	input  logic [15:0] color_green,
	input  logic [15:0] color_blue,
	input  logic [15:0] end_red,
	input  logic [15:0] end_green,
	input  logic [15:0] end_blue,
	input  logic [15:0] interval,
	input  logic [7:0]  blink_count,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  result_kind,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue,
	output logic        last
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RES} state_t;
	typedef enum logic [2:0] {
		MD_IDLE, MD_ON, MD_OFF, MD_BLINK_ON, MD_BLINK_OFF, MD_FADE
	} mode_t;

	function automatic logic [rgbfe_pkg::CNT_W-1:0] div10(
		input logic [rgbfe_pkg::FIELD_W-1:0] v);
		logic [31:0] p;
		p = 32'(v) * 32'd52429;
		div10 = p[31:19];
	endfunction

	state_t                        state_q;
	mode_t                         mode_q;
	rgbfe_pkg::color_t [2:0]       base_q;
	logic [15:0]                   step_q;
	logic [rgbfe_pkg::CNT_W-1:0]   target_q;
	logic [rgbfe_pkg::CNT_W-1:0]   period_q;
	logic [rgbfe_pkg::CNT_W-1:0]   tick_q;
	logic [1:0]                    out_kind_q;
	rgbfe_pkg::color_t [2:0]       out_col_q;
	logic                          out_last_q;
	logic                          sec_pend_q;
	rgbfe_pkg::color_t [2:0]       sec_col_q;

	rgbfe_pkg::color_t [2:0]       col;
	rgbfe_pkg::color_t [2:0]       endc;
	rgbfe_pkg::color_t [2:0]       lvl;
	logic [2:0]                    lane_busy;
	rgbfe_pkg::lane_ctrl_t         lane_ctrl;
	logic [rgbfe_pkg::CNT_W-1:0]   ival_div10;
	logic                          accept;
	logic                          tick_active;
	logic                          tick_fire;
	logic [rgbfe_pkg::CNT_W-1:0]   tick_next;
	logic [15:0]                   step_next;
	logic                          fade_done;
	logic                          blink_done;
	logic                          blink_ok;
	logic                          fade_ok;

	always_comb begin
		col[0]      = rgbfe_pkg::sat_color(color_red);
		col[1]      = rgbfe_pkg::sat_color(color_green);
		col[2]      = rgbfe_pkg::sat_color(color_blue);
		endc[0]     = rgbfe_pkg::sat_color(end_red);
		endc[1]     = rgbfe_pkg::sat_color(end_green);
		endc[2]     = rgbfe_pkg::sat_color(end_blue);
		ival_div10  = div10(interval);
		cmd_ready   = (state_q == ST_IDLE);
		accept      = cmd_valid && cmd_ready;
		tick_active = (mode_q == MD_BLINK_ON) || (mode_q == MD_BLINK_OFF) ||
			(mode_q == MD_FADE);
		tick_next   = tick_q + 1'b1;
		tick_fire   = accept && (kind == rgbfe_pkg::KIND_TICK) && tick_active &&
			(tick_next >= period_q);
		step_next   = step_q + 1'b1;
		fade_done   = (step_next >= 16'(target_q));
		blink_done  = (target_q != '0) && (step_next[15:1] >= 15'(target_q));
		blink_ok    = (interval >= rgbfe_pkg::BLINK_MIN);
		fade_ok     = (interval >= rgbfe_pkg::FADE_MIN);
		lane_ctrl.start   = accept && (kind == rgbfe_pkg::KIND_FADE) && fade_ok;
		lane_ctrl.advance = tick_fire && (mode_q == MD_FADE);
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		rgbfe_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (lane_ctrl),
			.fade_from (col[g]),
			.fade_to   (endc[g]),
			.divisor   (ival_div10),
			.busy      (lane_busy[g]),
			.level     (lvl[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MD_IDLE;
			base_q     <= '0;
			step_q     <= '0;
			target_q   <= '0;
			period_q   <= '0;
			tick_q     <= '0;
			out_kind_q <= rgbfe_pkg::RES_COLOR;
			out_col_q  <= '0;
			out_last_q <= 1'b0;
			sec_pend_q <= 1'b0;
			sec_col_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_last_q <= 1'b1;
						sec_pend_q <= 1'b0;
						out_kind_q <= rgbfe_pkg::RES_COLOR;
						out_col_q  <= '0;
						case (kind)
							rgbfe_pkg::KIND_TICK: begin
								if (tick_active) begin
									if (tick_next < period_q) begin
										tick_q <= tick_next;
									end else begin
										tick_q  <= '0;
										step_q  <= step_next;
										state_q <= ST_RES;
										if (mode_q == MD_FADE) begin
											out_col_q <= lvl;
											if (fade_done) begin
												mode_q <= MD_IDLE;
											end
										end else begin
											out_col_q <= step_q[0] ? base_q : '0;
											if (blink_done) begin
												out_last_q <= 1'b0;
												sec_pend_q <= 1'b1;
												sec_col_q  <= (mode_q == MD_BLINK_OFF) ?
													'0 : base_q;
												mode_q     <= MD_IDLE;
											end
										end
									end
								end
							end
							rgbfe_pkg::KIND_ON: begin
								mode_q    <= MD_ON;
								base_q    <= col;
								out_col_q <= col;
								state_q   <= ST_RES;
							end
							rgbfe_pkg::KIND_OFF: begin
								mode_q  <= MD_OFF;
								base_q  <= '0;
								state_q <= ST_RES;
							end
							rgbfe_pkg::KIND_BLINK_ON, rgbfe_pkg::KIND_BLINK_OFF: begin
								state_q <= ST_RES;
								if (blink_ok) begin
									base_q     <= col;
									mode_q     <= (kind == rgbfe_pkg::KIND_BLINK_ON) ?
										MD_BLINK_ON : MD_BLINK_OFF;
									target_q   <= rgbfe_pkg::CNT_W'(blink_count);
									period_q   <= ival_div10;
									step_q     <= '0;
									tick_q     <= '0;
									out_kind_q <= rgbfe_pkg::RES_ACCEPT;
								end else begin
									out_kind_q <= rgbfe_pkg::RES_REJECT;
								end
							end
							rgbfe_pkg::KIND_FADE: begin
								if (fade_ok) begin
									mode_q     <= MD_FADE;
									target_q   <= ival_div10;
									base_q     <= col;
									period_q   <= rgbfe_pkg::CNT_W'(1);
									step_q     <= '0;
									tick_q     <= '0;
									out_kind_q <= rgbfe_pkg::RES_ACCEPT;
									state_q    <= ST_DIV;
								end else begin
									out_kind_q <= rgbfe_pkg::RES_REJECT;
									state_q    <= ST_RES;
								end
							end
							default: begin
								out_kind_q <= rgbfe_pkg::RES_REJECT;
								state_q    <= ST_RES;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (lane_busy == '0) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (res_ready) begin
						if (sec_pend_q) begin
							out_col_q  <= sec_col_q;
							out_last_q <= 1'b1;
							sec_pend_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid   = (state_q == ST_RES);
	assign result_kind = out_kind_q;
	assign red         = rgbfe_pkg::FIELD_W'(out_col_q[0]);
	assign green       = rgbfe_pkg::FIELD_W'(out_col_q[1]);
	assign blue        = rgbfe_pkg::FIELD_W'(out_col_q[2]);
	assign last        = out_last_q;

endmodule

@@ sv/rgbfe_checker.sv @@
module rgbfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  result_kind,
	input logic [15:0] red,
	input logic [15:0] green,
	input logic [15:0] blue,
	input logic        last
);

	// hold a stalled item
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result_kind) &&
		$stable(red) && $stable(green) && $stable(blue) && $stable(last))
		else $error("result item changed while stalled");

	a_status_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (result_kind != rgbfe_pkg::RES_COLOR) |->
		(red == 16'd0) && (green == 16'd0) && (blue == 16'd0) && last)
		else $error("status item carries color or is not last");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !cmd_ready)
		else $error("command taken while a result is pending");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last |=> res_valid && last &&
		(result_kind == rgbfe_pkg::RES_COLOR))
		else $error("final color item missing after non-last item");

endmodule

bind rgb_led_blink_fade_engine rgbfe_checker u_rgbfe_checker (.*);
